// File: rtl/dpam_pkg.sv
// ----------------------------------------------------------------------------
// Dense polynomial add/multiply package
// Shared types, operation codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package dpam_pkg;

    localparam int COEF_W    = 16;
    localparam int VALUE_W   = 40;
    localparam int EXP_W     = 5;
    localparam int OUT_EXP_W = 6;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_GO     = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [EXP_W-1:0]          t_exp;
    typedef logic [OUT_EXP_W-1:0]      t_out_exp;
    typedef logic [OP_W-1:0]           t_op;

    // Commands broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic clear;
        logic rot_a;
        logic rot_b;
        logic acc_clear;
        logic acc_step;
    } t_cell_ctrl;

endpackage

// File: rtl/dpam_cell.sv
// ----------------------------------------------------------------------------
// Polynomial chain cell
// Holds one coefficient of A and of B and one accumulator of the transposed
// convolution chain; A and B can rotate toward cell zero.
// ----------------------------------------------------------------------------
module dpam_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dpam_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_sel,
    input  dpam_pkg::t_coef     i_coef,
    input  dpam_pkg::t_coef     i_a_nbr,
    input  dpam_pkg::t_coef     i_b_nbr,
    input  dpam_pkg::t_coef     i_x,
    input  dpam_pkg::t_value    i_acc_nbr,
    output dpam_pkg::t_coef     o_a,
    output dpam_pkg::t_coef     o_b,
    output dpam_pkg::t_value    o_acc,
    output dpam_pkg::t_value    o_acc_n,
    output logic                o_a_hit,
    output logic                o_b_hit
);
    import dpam_pkg::*;

    t_coef              r_a;
    t_coef              n_a;
    t_coef              r_b;
    t_coef              n_b;
    t_value             r_acc;
    t_value             n_acc;
    logic signed [31:0] w_prod;

    assign w_prod = 32'(r_a) * 32'(i_x);

    always_comb begin
        n_a = r_a;
        if (i_ctrl.clear) begin
            n_a = '0;
        end else if (i_ctrl.load_a && i_sel && (r_a == '0)) begin
            n_a = i_coef;
        end else if (i_ctrl.rot_a) begin
            n_a = i_a_nbr;
        end

        n_b = r_b;
        if (i_ctrl.clear) begin
            n_b = '0;
        end else if (i_ctrl.load_b && i_sel && (r_b == '0)) begin
            n_b = i_coef;
        end else if (i_ctrl.rot_b) begin
            n_b = i_b_nbr;
        end

        // Transposed form: each step adds this cell's product to the
        // partial sum handed down from the next cell.
        n_acc = r_acc;
        if (i_ctrl.acc_clear) begin
            n_acc = '0;
        end else if (i_ctrl.acc_step) begin
            n_acc = i_acc_nbr + VALUE_W'(w_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
        end else begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_acc   = r_acc;
    assign o_acc_n = n_acc;
    assign o_a_hit = i_sel && (r_a != '0);
    assign o_b_hit = i_sel && (r_b != '0);

endmodule

// File: rtl/dense_polynomial_add_multiply.sv
// ----------------------------------------------------------------------------
// Dense polynomial add/multiply
// Holds polynomials A and B in a chain of cells and emits their sum or
// product one coefficient per cycle.
// ----------------------------------------------------------------------------
// Usage: an item is taken at a clock edge where i_start is high and o_busy is
// low. Load A / load B and clear leave o_busy low. A load that hits a nonzero
// coefficient gives one error result on the cycle after the transfer. Go
// raises o_busy and walks the cell chain once: each step broadcasts one
// coefficient of B (product) or rotates both polynomials past cell zero
// (sum). The pass has max(result degree + 1, TERMS) steps. The coefficient
// for exponent k is formed at step k of the pass and then registered onto
// the outputs; last marks the highest exponent. Every result is shown on
// o_valid for one cycle and the receiver has no way to stall it. The mode
// register is written through i_cfg_we / i_cfg_wdata; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// Reset clears both polynomials, their degrees and any pass, and sets mode
// to product.
// ----------------------------------------------------------------------------
module dense_polynomial_add_multiply #(
    parameter int TERMS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  dpam_pkg::t_op        i_op,
    input  dpam_pkg::t_exp       i_exponent,
    input  dpam_pkg::t_coef      i_coefficient,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    output logic                 o_valid,
    output dpam_pkg::t_out_exp   o_term_exponent,
    output dpam_pkg::t_value     o_term_value,
    output logic                 o_attach_error,
    output logic                 o_last
);
    import dpam_pkg::*;

    localparam int DW = $clog2(TERMS);
    localparam int CW = $clog2(2 * TERMS - 1);
    localparam logic [CW-1:0] LAST_ROT = CW'(TERMS - 1);

    t_coef      w_a     [TERMS];
    t_coef      w_b     [TERMS];
    t_value     w_acc   [TERMS];
    t_value     w_acc_n [TERMS];
    logic [TERMS-1:0] w_sel;
    logic [TERMS-1:0] w_a_hit;
    logic [TERMS-1:0] w_b_hit;
    t_cell_ctrl w_ctrl;
    t_coef      w_x;

    logic          r_mode;
    logic          n_mode;
    logic          r_busy;
    logic          n_busy;
    logic          r_sum;
    logic          n_sum;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] r_rdeg;
    logic [CW-1:0] n_rdeg;
    logic [CW-1:0] r_end;
    logic [CW-1:0] n_end;
    logic [DW-1:0] r_a_deg;
    logic [DW-1:0] n_a_deg;
    logic [DW-1:0] r_b_deg;
    logic [DW-1:0] n_b_deg;
    logic          r_out_valid;
    logic          n_out_valid;
    t_out_exp      r_out_exp;
    t_out_exp      n_out_exp;
    t_value        r_out_val;
    t_value        n_out_val;
    logic          r_out_err;
    logic          n_out_err;
    logic          r_out_last;
    logic          n_out_last;

    logic          w_accept;
    logic          w_go;
    logic          w_exp_ok;
    logic          w_in_rot;
    logic          w_err;
    logic [DW-1:0] w_exp_d;
    logic [DW-1:0] w_max_deg;
    logic [CW-1:0] w_new_rdeg;
    logic signed [COEF_W:0] w_pair;
    t_value        w_sum_val;

    genvar k;
    generate
        for (k = 0; k < TERMS; k++) begin : g_cell
            assign w_sel[k] = (i_exponent == EXP_W'(k));
            dpam_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_sel     (w_sel[k]),
                .i_coef    (i_coefficient),
                .i_a_nbr   (w_a[(k + 1) % TERMS]),
                .i_b_nbr   (w_b[(k + 1) % TERMS]),
                .i_x       (w_x),
                .i_acc_nbr ((k == TERMS - 1) ? t_value'(0) : w_acc[(k + 1) % TERMS]),
                .o_a       (w_a[k]),
                .o_b       (w_b[k]),
                .o_acc     (w_acc[k]),
                .o_acc_n   (w_acc_n[k]),
                .o_a_hit   (w_a_hit[k]),
                .o_b_hit   (w_b_hit[k])
            );
        end
    endgenerate

    assign w_accept   = i_start && !r_busy;
    assign w_go       = w_accept && (i_op == OP_GO);
    assign w_exp_ok   = ({1'b0, i_exponent} < OUT_EXP_W'(TERMS));
    assign w_exp_d    = i_exponent[DW-1:0];
    assign w_in_rot   = (r_cnt <= LAST_ROT);
    assign w_max_deg  = (r_a_deg >= r_b_deg) ? r_a_deg : r_b_deg;
    assign w_new_rdeg = r_mode ? (CW'(r_a_deg) + CW'(r_b_deg)) : CW'(w_max_deg);
    // B has been rotated all the way round once the counter passes TERMS - 1.
    assign w_x        = w_in_rot ? w_b[0] : t_coef'(0);
    assign w_pair     = {w_a[0][COEF_W-1], w_a[0]} + {w_b[0][COEF_W-1], w_b[0]};
    assign w_sum_val  = {{(VALUE_W - COEF_W - 9){w_pair[COEF_W]}}, w_pair, 8'b0};
    assign w_err      = w_accept && (((i_op == OP_LOAD_A) && (|w_a_hit))
                                  || ((i_op == OP_LOAD_B) && (|w_b_hit)));

    always_comb begin
        w_ctrl.load_a    = w_accept && (i_op == OP_LOAD_A);
        w_ctrl.load_b    = w_accept && (i_op == OP_LOAD_B);
        w_ctrl.clear     = w_accept && (i_op == OP_CLEAR);
        w_ctrl.rot_a     = r_busy && r_sum && w_in_rot;
        w_ctrl.rot_b     = r_busy && w_in_rot;
        w_ctrl.acc_clear = w_go;
        w_ctrl.acc_step  = r_busy && !r_sum;
    end

    always_comb begin
        n_mode      = i_cfg_we ? i_cfg_wdata : r_mode;
        n_busy      = r_busy;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_rdeg      = r_rdeg;
        n_end       = r_end;
        n_a_deg     = r_a_deg;
        n_b_deg     = r_b_deg;
        n_out_valid = 1'b0;
        n_out_exp   = r_out_exp;
        n_out_val   = r_out_val;
        n_out_err   = r_out_err;
        n_out_last  = r_out_last;

        if (r_busy) begin
            if (r_cnt <= r_rdeg) begin
                n_out_valid = 1'b1;
                n_out_exp   = OUT_EXP_W'(r_cnt);
                n_out_val   = r_sum ? w_sum_val : w_acc_n[0];
                n_out_err   = 1'b0;
                n_out_last  = (r_cnt == r_rdeg);
            end
            if (r_cnt == r_end) begin
                n_busy = 1'b0;
            end
            n_cnt = r_cnt + CW'(1);
        end else if (w_accept) begin
            case (i_op)
                OP_LOAD_A: begin
                    if (w_exp_ok && !w_err && (w_exp_d > r_a_deg)) begin
                        n_a_deg = w_exp_d;
                    end
                end
                OP_LOAD_B: begin
                    if (w_exp_ok && !w_err && (w_exp_d > r_b_deg)) begin
                        n_b_deg = w_exp_d;
                    end
                end
                OP_GO: begin
                    n_busy = 1'b1;
                    n_sum  = !r_mode;
                    n_cnt  = '0;
                    n_rdeg = w_new_rdeg;
                    n_end  = (w_new_rdeg > LAST_ROT) ? w_new_rdeg : LAST_ROT;
                end
                default: begin
                    n_a_deg = '0;
                    n_b_deg = '0;
                end
            endcase
            if (w_err) begin
                n_out_valid = 1'b1;
                n_out_exp   = OUT_EXP_W'(i_exponent);
                n_out_val   = '0;
                n_out_err   = 1'b1;
                n_out_last  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b1;
            r_busy      <= 1'b0;
            r_sum       <= 1'b0;
            r_cnt       <= '0;
            r_rdeg      <= '0;
            r_end       <= '0;
            r_a_deg     <= '0;
            r_b_deg     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_busy      <= n_busy;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_rdeg      <= n_rdeg;
            r_end       <= n_end;
            r_a_deg     <= n_a_deg;
            r_b_deg     <= n_b_deg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_exp  <= n_out_exp;
        r_out_val  <= n_out_val;
        r_out_err  <= n_out_err;
        r_out_last <= n_out_last;
    end

    assign o_busy          = r_busy;
    assign o_valid         = r_out_valid;
    assign o_term_exponent = r_out_exp;
    assign o_term_value    = r_out_val;
    assign o_attach_error  = r_out_err;
    assign o_last          = r_out_last;

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_attach_error) |-> (o_last && (o_term_value == '0)))
        else $error("attach error result carries a value or lacks last");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= r_end))
        else $error("pass counter ran past the end of the pass");

    a_pass_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_cnt == r_end)) |=> !r_busy)
        else $error("pass did not finish at its last step");

    a_go_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_attach_error) |-> $past(r_busy))
        else $error("coefficient result outside a pass");

    a_chain_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_attach_error && !r_sum) |-> (o_term_value == w_acc[0]))
        else $error("product result differs from the head of the chain");

endmodule
